// ----- hdl/ipwm_pkg.sv -----
`default_nettype none

package ipwm_pkg;

   // image geometry
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int PATTERN_MAX = 3;
   localparam int ADDR_W      = $clog2(MAX_WIDTH);

   // field widths
   localparam int CHAR_W     = 8;
   localparam int COORD_W    = 10;
   localparam int DIM_W      = 11;
   localparam int PDIM_W     = 2;
   localparam int COUNT_W    = 21;
   localparam int PROW_W     = 3 * CHAR_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_TOP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_MIDDLE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BOTTOM = 3'd6;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // position of a pixel in flight
   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               end_image;
   } stage_info_type;

   // pattern in use, sizes already clamped
   typedef struct packed {
      logic [PDIM_W-1:0]            width;
      logic [PDIM_W-1:0]            height;
      logic [2:0][PROW_W-1:0]       rows;
   } pattern_cfg_type;

   typedef struct packed {
      logic [COORD_W-1:0] match_row;
      logic [COORD_W-1:0] match_col;
      logic [COUNT_W-1:0] match_total;
      logic               is_summary;
      logic               last;
   } result_type;

   // queue status toward the pipeline
   typedef struct packed {
      logic not_empty;
      logic room_for_two;
   } queue_status_type;

endpackage

`default_nettype wire

// ----- hdl/ipwm_ram.sv -----
`default_nettype none

module ipwm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port (read returns old data)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- hdl/ipwm_window.sv -----
`default_nettype none

module ipwm_window (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          fire,
   input  wire ipwm_pkg::stage_info_type      info,
   input  wire logic [ipwm_pkg::CHAR_W-1:0]   pixel,
   input  wire logic [2*ipwm_pkg::CHAR_W-1:0] column,
   input  wire ipwm_pkg::pattern_cfg_type     pattern,
   output ipwm_pkg::result_type               result0,
   output ipwm_pkg::result_type               result1,
   output logic [1:0]                         result_count
);

   import ipwm_pkg::*;

   logic [2:0][2:0][CHAR_W-1:0] window_ff, window_in;   // [row][col], row 2 / col 2 newest
   logic [COUNT_W-1:0]          count_ff, count_in, total;
   logic [1:0]                  row_off, col_off, pr, pc;
   logic                        mismatch, fits, matched;
   result_type                  match_res, summary_res;

   // shift left and load the new column
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         window_in[r][0] = window_ff[r][1];
         window_in[r][1] = window_ff[r][2];
      end
      window_in[0][2] = column[CHAR_W-1:0];
      window_in[1][2] = column[2*CHAR_W-1:CHAR_W];
      window_in[2][2] = pixel;
   end

   // up to nine byte compares against the pattern anchored at the bottom-right
   always_comb begin
      row_off  = 2'd3 - pattern.height;
      col_off  = 2'd3 - pattern.width;
      mismatch = 1'b0;
      pr       = '0;
      pc       = '0;
      for (int wr = 0; wr < 3; wr++) begin
         for (int wc = 0; wc < 3; wc++) begin
            if (2'(wr) >= row_off && 2'(wc) >= col_off) begin
               pr = 2'(wr) - row_off;
               pc = 2'(wc) - col_off;
               if (window_in[wr][wc] != pattern.rows[pr][CHAR_W*pc +: CHAR_W]) begin
                  mismatch = 1'b1;
               end
            end
         end
      end
   end

   // window must lie inside the image
   assign fits = ({1'b0, info.row} + DIM_W'(1) >= DIM_W'(pattern.height)) &&
                 ({1'b0, info.col} + DIM_W'(1) >= DIM_W'(pattern.width));
   assign matched = fits && !mismatch;

   // saturating match count
   assign total    = (matched && count_ff != COUNT_MAX) ? count_ff + COUNT_W'(1) : count_ff;
   assign count_in = info.end_image ? '0 : total;

   // result items
   always_comb begin
      match_res.match_row   = info.row + COORD_W'(1) - COORD_W'(pattern.height);
      match_res.match_col   = info.col + COORD_W'(1) - COORD_W'(pattern.width);
      match_res.match_total = total;
      match_res.is_summary  = 1'b0;
      match_res.last        = !info.end_image;

      summary_res.match_row   = '0;
      summary_res.match_col   = '0;
      summary_res.match_total = total;
      summary_res.is_summary  = 1'b1;
      summary_res.last        = 1'b1;

      result0 = matched ? match_res : summary_res;
      result1 = summary_res;
      if (matched && info.end_image) begin
         result_count = 2'd2;
      end else if (matched || info.end_image) begin
         result_count = 2'd1;
      end else begin
         result_count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         count_ff  <= '0;
      end else if (fire) begin
         window_ff <= window_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/ipwm_rsp_queue.sv -----
`default_nettype none

module ipwm_rsp_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [1:0]             push_count,
   input  wire ipwm_pkg::result_type   push0,
   input  wire ipwm_pkg::result_type   push1,
   input  wire logic                   pop,
   output ipwm_pkg::result_type        head,
   output ipwm_pkg::queue_status_type  status
);

   import ipwm_pkg::*;

   result_type             entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   do_pop;

   assign head                = entry_ff[rd_ptr_ff];
   assign status.not_empty    = (count_ff != '0);
   assign status.room_for_two = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign do_pop              = pop && status.not_empty;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(do_pop);
      count_in  = count_ff + RSP_CNT_W'(push_count) - RSP_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // up to two entries written per cycle
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= push1;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/image_pattern_window_match_unit.sv -----
`default_nettype none

// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_ready  | req_pixel_char
// rsp     | out       | rsp_valid/rsp_ready  | rsp_match_row, rsp_match_col, rsp_match_total,
//         |           |                      | rsp_is_summary, rsp_last
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One pixel per cycle: the line-store RAM takes one read (at accept) and one write
// (as the pixel leaves stage 1) per pixel; back-to-back pixels on the same column are forwarded.
// A result passes through the stage 1 register and then the result queue before it shows
// on rsp; an end-of-image pixel with a match yields two results.
// Input stalls only when the 4-entry result queue has fewer than two free slots.
// Reset is synchronous; the line stores need no clearing pass.

module image_pattern_window_match_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [ipwm_pkg::CHAR_W-1:0]       req_pixel_char,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [ipwm_pkg::COORD_W-1:0]           rsp_match_row,
   output logic [ipwm_pkg::COORD_W-1:0]           rsp_match_col,
   output logic [ipwm_pkg::COUNT_W-1:0]           rsp_match_total,
   output logic                                   rsp_is_summary,
   output logic                                   rsp_last,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ipwm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ipwm_pkg::CSR_DATA_W-1:0]   csr_data
);

   import ipwm_pkg::*;

   // configuration registers
   logic [DIM_W-1:0]       img_width_ff, img_height_ff;
   logic [PDIM_W-1:0]      pat_width_ff, pat_height_ff;
   logic [2:0][PROW_W-1:0] pat_rows_ff;
   logic [DIM_W-1:0]       width_eff, height_eff;
   pattern_cfg_type        pattern;

   // front counters and stage 1
   logic [COORD_W-1:0]     row_ff, row_in, col_ff, col_in;
   logic                   end_row, end_image;
   logic                   req_fire, s1_fire;
   logic                   s1_valid_ff, s1_valid_in;
   stage_info_type         s1_info_ff;
   logic [CHAR_W-1:0]      s1_pixel_ff;
   logic                   fwd_hit_ff, fwd_hit_in;
   logic [2*CHAR_W-1:0]    fwd_data_ff;

   logic [2*CHAR_W-1:0]    ram_rdata, column, wr_data;
   result_type             res0, res1, head;
   logic [1:0]             res_count;
   queue_status_type       q_status;

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff  <= DIM_W'(MAX_WIDTH);
         img_height_ff <= DIM_W'(MAX_HEIGHT);
         pat_width_ff  <= PDIM_W'(PATTERN_MAX);
         pat_height_ff <= PDIM_W'(PATTERN_MAX);
         pat_rows_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:    img_width_ff   <= csr_data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:   img_height_ff  <= csr_data[DIM_W-1:0];
            CSR_PATTERN_WIDTH:  pat_width_ff   <= csr_data[PDIM_W-1:0];
            CSR_PATTERN_HEIGHT: pat_height_ff  <= csr_data[PDIM_W-1:0];
            CSR_PATTERN_TOP:    pat_rows_ff[0] <= csr_data[PROW_W-1:0];
            CSR_PATTERN_MIDDLE: pat_rows_ff[1] <= csr_data[PROW_W-1:0];
            CSR_PATTERN_BOTTOM: pat_rows_ff[2] <= csr_data[PROW_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp sizes to their legal ranges
   always_comb begin
      if (img_width_ff == '0) begin
         width_eff = DIM_W'(1);
      end else if (img_width_ff > DIM_W'(MAX_WIDTH)) begin
         width_eff = DIM_W'(MAX_WIDTH);
      end else begin
         width_eff = img_width_ff;
      end
      if (img_height_ff == '0) begin
         height_eff = DIM_W'(1);
      end else if (img_height_ff > DIM_W'(MAX_HEIGHT)) begin
         height_eff = DIM_W'(MAX_HEIGHT);
      end else begin
         height_eff = img_height_ff;
      end
      pattern.width  = (pat_width_ff == '0) ? PDIM_W'(1) : pat_width_ff;
      pattern.height = (pat_height_ff == '0) ? PDIM_W'(1) : pat_height_ff;
      pattern.rows   = pat_rows_ff;
   end

   // handshakes
   assign s1_fire   = s1_valid_ff && q_status.room_for_two;
   assign req_ready = !s1_valid_ff || q_status.room_for_two;
   assign req_fire  = req_valid && req_ready;

   // raster position of the incoming pixel
   assign end_row   = ({1'b0, col_ff} + DIM_W'(1) >= width_eff);
   assign end_image = end_row && ({1'b0, row_ff} + DIM_W'(1) >= height_eff);

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (req_fire) begin
         priority if (end_image) begin
            row_in = '0;
            col_in = '0;
         end else if (end_row) begin
            row_in = row_ff + COORD_W'(1);
            col_in = '0;
         end else begin
            col_in = col_ff + COORD_W'(1);
         end
      end
   end

   // stage 1 occupancy and forwarding of a same-column write
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      fwd_hit_in = s1_fire && (s1_info_ff.col[ADDR_W-1:0] == col_ff[ADDR_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= s1_valid_in;
         if (req_fire) begin
            fwd_hit_ff <= fwd_hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_info_ff.row       <= row_ff;
         s1_info_ff.col       <= col_ff;
         s1_info_ff.end_image <= end_image;
         s1_pixel_ff          <= req_pixel_char;
         fwd_data_ff          <= wr_data;
      end
   end

   // line stores: entry holds {previous row, row before that}
   assign column  = fwd_hit_ff ? fwd_data_ff : ram_rdata;
   assign wr_data = {s1_pixel_ff, column[2*CHAR_W-1:CHAR_W]};

   ipwm_ram #(
      .WIDTH (2 * CHAR_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_info_ff.col[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (req_fire),
      .rd_addr (col_ff[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   // window compare and match counting
   ipwm_window u_window (
      .clock        (clock),
      .reset        (reset),
      .fire         (s1_fire),
      .info         (s1_info_ff),
      .pixel        (s1_pixel_ff),
      .column       (column),
      .pattern      (pattern),
      .result0      (res0),
      .result1      (res1),
      .result_count (res_count)
   );

   // result queue
   ipwm_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (s1_fire ? res_count : 2'd0),
      .push0      (res0),
      .push1      (res1),
      .pop        (rsp_ready),
      .head       (head),
      .status     (q_status)
   );

   assign rsp_valid       = q_status.not_empty;
   assign rsp_match_row   = head.match_row;
   assign rsp_match_col   = head.match_col;
   assign rsp_match_total = head.match_total;
   assign rsp_is_summary  = head.is_summary;
   assign rsp_last        = head.last;

endmodule

`default_nettype wire

// ----- verif/tb_image_pattern_window_match_unit.sv -----
`timescale 1ns / 1ps

module tb_image_pattern_window_match_unit;
   import ipwm_pkg::*;

   // index that decodes to no register
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam int RANDOM_PIXELS = 1150;
   localparam int QUIET_TAIL    = 200;
   localparam int SETTLE_CYCLES = 8;
   localparam int PRINT_CAP     = 50;
   // widest image used after priming; priming writes every column up to here
   localparam int MAX_RANDOM_W  = 10;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CHAR_W-1:0]     req_pixel_char = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [COORD_W-1:0]    rsp_match_row;
   logic [COORD_W-1:0]    rsp_match_col;
   logic [COUNT_W-1:0]    rsp_match_total;
   logic                  rsp_is_summary;
   logic                  rsp_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   image_pattern_window_match_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_char  (req_pixel_char),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_match_row   (rsp_match_row),
      .rsp_match_col   (rsp_match_col),
      .rsp_match_total (rsp_match_total),
      .rsp_is_summary  (rsp_is_summary),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #6 clock = ~clock;

   // shadow copy of the registers and of the window state
   logic [DIM_W-1:0]   cfg_img_w;
   logic [DIM_W-1:0]   cfg_img_h;
   logic [PDIM_W-1:0]  cfg_pat_w;
   logic [PDIM_W-1:0]  cfg_pat_h;
   logic [PROW_W-1:0]  cfg_pat_rows [3];
   logic [CHAR_W-1:0]  line_prev  [MAX_WIDTH];
   logic [CHAR_W-1:0]  line_prev2 [MAX_WIDTH];
   logic [CHAR_W-1:0]  win [3][3];
   logic [COORD_W-1:0] row_cnt;
   logic [COORD_W-1:0] col_cnt;
   logic [COUNT_W-1:0] hit_cnt;

   logic [CHAR_W-1:0] pixel_q [$];
   result_type        reports_due [$];
   result_type        got;
   result_type        want;

   bit req_taken;
   bit csr_taken;
   bit gaps_on;
   int send_gap;
   int stall_gap;
   int pixels_sent;
   int pixels_taken;
   int hits_seen;
   int images_done;
   int csr_writes;
   int mismatch_count;

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      return (v < 1) ? 1 : (v > hi) ? hi : v;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   // shift one pixel into the window, compare, queue the results it causes
   task automatic advance_window(input logic [CHAR_W-1:0] px);
      int unsigned w, h, pw, ph;
      int r, k;
      logic [ADDR_W-1:0] c;
      bit hit, end_row, end_img;
      result_type res;
      w  = clamp_dim(cfg_img_w, MAX_WIDTH);
      h  = clamp_dim(cfg_img_h, MAX_HEIGHT);
      pw = clamp_dim(cfg_pat_w, PATTERN_MAX);
      ph = clamp_dim(cfg_pat_h, PATTERN_MAX);
      c  = col_cnt;
      for (r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = line_prev2[c];
      win[1][2] = line_prev[c];
      win[2][2] = px;
      line_prev2[c] = line_prev[c];
      line_prev[c]  = px;

      // pattern sits in the bottom-right corner of the window
      hit = (row_cnt + 1 >= ph) && (col_cnt + 1 >= pw);
      for (r = 0; r < ph; r++)
         for (k = 0; k < pw; k++)
            if (cfg_pat_rows[r][CHAR_W*k +: CHAR_W] != win[3-ph+r][3-pw+k])
               hit = 1'b0;

      end_row = (col_cnt + 1 >= w);
      end_img = end_row && (row_cnt + 1 >= h);

      if (hit) begin
         if (hit_cnt != COUNT_MAX)
            hit_cnt = hit_cnt + 1'b1;
         res.match_row   = COORD_W'(row_cnt + 1 - ph);
         res.match_col   = COORD_W'(col_cnt + 1 - pw);
         res.match_total = hit_cnt;
         res.is_summary  = 1'b0;
         res.last        = !end_img;
         reports_due.push_back(res);
      end

      if (end_img) begin
         res.match_row   = '0;
         res.match_col   = '0;
         res.match_total = hit_cnt;
         res.is_summary  = 1'b1;
         res.last        = 1'b1;
         reports_due.push_back(res);
         row_cnt = '0;
         col_cnt = '0;
         hit_cnt = '0;
      end else if (end_row) begin
         col_cnt = '0;
         row_cnt = row_cnt + 1'b1;
      end else begin
         col_cnt = col_cnt + 1'b1;
      end
   endtask

   // monitor: track accepted transactions on all three channels
   always @(posedge clock) begin
      if (reset) begin
         cfg_img_w = DIM_W'(MAX_WIDTH);
         cfg_img_h = DIM_W'(MAX_HEIGHT);
         cfg_pat_w = PDIM_W'(PATTERN_MAX);
         cfg_pat_h = PDIM_W'(PATTERN_MAX);
         for (int i = 0; i < 3; i++) begin
            cfg_pat_rows[i] = '0;
            for (int j = 0; j < 3; j++)
               win[i][j] = '0;
         end
         for (int i = 0; i < MAX_WIDTH; i++) begin
            line_prev[i]  = '0;
            line_prev2[i] = '0;
         end
         row_cnt   = '0;
         col_cnt   = '0;
         hit_cnt   = '0;
         req_taken = 1'b0;
         csr_taken = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            advance_window(req_pixel_char);
            pixels_taken++;
         end
         req_taken = req_valid && req_ready;

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:    cfg_img_w       = csr_data[DIM_W-1:0];
               CSR_IMAGE_HEIGHT:   cfg_img_h       = csr_data[DIM_W-1:0];
               CSR_PATTERN_WIDTH:  cfg_pat_w       = csr_data[PDIM_W-1:0];
               CSR_PATTERN_HEIGHT: cfg_pat_h       = csr_data[PDIM_W-1:0];
               CSR_PATTERN_TOP:    cfg_pat_rows[0] = csr_data[PROW_W-1:0];
               CSR_PATTERN_MIDDLE: cfg_pat_rows[1] = csr_data[PROW_W-1:0];
               CSR_PATTERN_BOTTOM: cfg_pat_rows[2] = csr_data[PROW_W-1:0];
               default: ;
            endcase
            csr_writes++;
         end
         csr_taken = csr_valid && csr_ready;

         if (rsp_valid && rsp_ready) begin
            got.match_row   = rsp_match_row;
            got.match_col   = rsp_match_col;
            got.match_total = rsp_match_total;
            got.is_summary  = rsp_is_summary;
            got.last        = rsp_last;
            if (reports_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result row %0d col %0d total %0d sum %0b last %0b",
                  got.match_row, got.match_col, got.match_total, got.is_summary, got.last));
            end else begin
               want = reports_due.pop_front();
               if (got !== want)
                  report_mismatch($sformatf(
                     "got row %0d col %0d total %0d sum %0b last %0b, want %0d %0d %0d %0b %0b",
                     got.match_row, got.match_col, got.match_total, got.is_summary, got.last,
                     want.match_row, want.match_col, want.match_total, want.is_summary,
                     want.last));
               if (want.is_summary)
                  images_done++;
               else
                  hits_seen++;
            end
         end
      end
   end

   // pixel driver, fed from pixel_q
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pixel_q.size() == 0) begin
            req_valid <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 15) - 1;
            req_valid <= 1'b0;
         end else begin
            req_valid      <= 1'b1;
            req_pixel_char <= pixel_q.pop_front();
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_gap = 0;
      end else if (stall_gap > 0) begin
         stall_gap--;
         rsp_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
         stall_gap = $urandom_range(1, 15) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      while (!csr_taken)
         @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // all pixels taken, all results back, then let the pipeline settle
   task automatic wait_idle();
      @(negedge clock);
      while (pixels_sent != pixels_taken || reports_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_pixel(input logic [CHAR_W-1:0] px);
      pixel_q.push_back(px);
      pixels_sent++;
   endtask

   // size fields carry noise in the unused upper data bits
   task automatic configure(input logic [DIM_W-1:0] w_reg, h_reg,
                            input logic [PDIM_W-1:0] pw_reg, ph_reg,
                            input logic [PROW_W-1:0] rows [3]);
      logic [CSR_DATA_W-1:0] noisy;
      noisy = CSR_DATA_W'($urandom);
      noisy[DIM_W-1:0] = w_reg;
      write_csr(CSR_IMAGE_WIDTH, noisy);
      noisy = CSR_DATA_W'($urandom);
      noisy[DIM_W-1:0] = h_reg;
      write_csr(CSR_IMAGE_HEIGHT, noisy);
      noisy = CSR_DATA_W'($urandom);
      noisy[PDIM_W-1:0] = pw_reg;
      write_csr(CSR_PATTERN_WIDTH, noisy);
      noisy = CSR_DATA_W'($urandom);
      noisy[PDIM_W-1:0] = ph_reg;
      write_csr(CSR_PATTERN_HEIGHT, noisy);
      write_csr(CSR_PATTERN_TOP, rows[0]);
      write_csr(CSR_PATTERN_MIDDLE, rows[1]);
      write_csr(CSR_PATTERN_BOTTOM, rows[2]);
      if ($urandom_range(0, 3) == 0)
         write_csr(CSR_SPARE, CSR_DATA_W'($urandom));
   endtask

   // one image mostly over a two-symbol alphabet with the pattern planted up to three times;
   // optionally cut short so the next setup lands mid-image
   task automatic run_image(input logic [DIM_W-1:0] w_reg, h_reg,
                            input logic [PDIM_W-1:0] pw_reg, ph_reg,
                            input bit cut_short, output int sent);
      int unsigned w, h, pw, ph, n, r0, c0, copies;
      int r, k, p;
      logic [CHAR_W-1:0] sym_a, sym_b;
      logic [PROW_W-1:0] rows [3];
      logic [CHAR_W-1:0] img [];
      w  = clamp_dim(w_reg, MAX_WIDTH);
      h  = clamp_dim(h_reg, MAX_HEIGHT);
      pw = clamp_dim(pw_reg, PATTERN_MAX);
      ph = clamp_dim(ph_reg, PATTERN_MAX);
      sym_a = CHAR_W'($urandom);
      sym_b = CHAR_W'($urandom);
      // cells outside the pattern size get noise, they must be ignored
      for (r = 0; r < 3; r++)
         for (k = 0; k < 3; k++)
            rows[r][CHAR_W*k +: CHAR_W] = (r < ph && k < pw) ?
               ($urandom_range(0, 1) ? sym_a : sym_b) : CHAR_W'($urandom);
      img = new[w * h];
      foreach (img[i])
         img[i] = ($urandom_range(0, 7) == 0) ? CHAR_W'($urandom) :
                  ($urandom_range(0, 1) ? sym_a : sym_b);
      if (ph <= h && pw <= w) begin
         copies = $urandom_range(0, 3);
         repeat (copies) begin
            r0 = $urandom_range(0, h - ph);
            c0 = $urandom_range(0, w - pw);
            for (r = 0; r < ph; r++)
               for (k = 0; k < pw; k++)
                  img[(r0 + r) * w + c0 + k] = rows[r][CHAR_W*k +: CHAR_W];
         end
      end
      wait_idle();
      configure(w_reg, h_reg, pw_reg, ph_reg, rows);
      n = (cut_short && w * h > 1) ? $urandom_range(1, w * h - 1) : w * h;
      @(posedge clock);
      for (p = 0; p < n; p++)
         send_pixel(img[p]);
      sent = n;
   endtask

   // stimulus sequence
   initial begin
      logic [PROW_W-1:0] pat [3];
      logic [DIM_W-1:0]  w_reg, h_reg;
      int sent, random_sent;

      gaps_on = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // prime both line stores over every column later images reach: two rows,
      // noise in the upper data bits, and the reset 3x3 pattern cannot fit
      write_csr(CSR_IMAGE_WIDTH, 24'hFFF800 | CSR_DATA_W'(MAX_RANDOM_W));
      write_csr(CSR_IMAGE_HEIGHT, 24'hFFF802);
      @(posedge clock);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      for (int i = 2; i < 2 * MAX_RANDOM_W; i++)
         send_pixel(CHAR_W'($urandom));

      // zero sizes clamp to one: single-pixel images, match and total together
      wait_idle();
      pat = '{24'hABCD00, 24'h123456, 24'hFEDCBA};
      configure('0, '0, '0, '0, pat);
      @(posedge clock);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'h00);

      // full 3x3 pattern of all-ones characters
      wait_idle();
      pat = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
      configure(DIM_W'(3), DIM_W'(3), PDIM_W'(3), PDIM_W'(3), pat);
      @(posedge clock);
      repeat (9) send_pixel(8'hFF);

      // shrink the image while the second row is in progress
      wait_idle();
      pat = '{24'h556261, 24'hAA6162, 24'h777777};
      configure(DIM_W'(4), DIM_W'(4), PDIM_W'(2), PDIM_W'(2), pat);
      @(posedge clock);
      send_pixel(8'h61);
      send_pixel(8'h62);
      send_pixel(8'h61);
      send_pixel(8'h62);
      send_pixel(8'h62);
      send_pixel(8'h61);
      wait_idle();
      configure(DIM_W'(2), DIM_W'(2), PDIM_W'(2), PDIM_W'(2), pat);
      @(posedge clock);
      send_pixel(8'h62);
      send_pixel(8'h61);
      send_pixel(8'h62);
      send_pixel(8'h62);
      send_pixel(8'h61);

      // tall one-column image with a vertical pattern
      run_image(DIM_W'(1), DIM_W'(60), PDIM_W'(1), PDIM_W'(3), 1'b0, sent);

      // random images, mostly small, some cut short; no gaps near the end
      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         gaps_on = (random_sent < RANDOM_PIXELS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
         w_reg = ($urandom_range(0, 19) == 0) ? DIM_W'(0) :
                 DIM_W'($urandom_range(1, MAX_RANDOM_W));
         h_reg = ($urandom_range(0, 19) == 0) ? DIM_W'(0) : DIM_W'($urandom_range(1, 6));
         run_image(w_reg, h_reg, PDIM_W'($urandom_range(0, 3)), PDIM_W'($urandom_range(0, 3)),
                   $urandom_range(0, 9) == 0, sent);
         random_sent += sent;
      end

      gaps_on = 1'b0;
      wait_idle();
      $display("Run covered %0d pixels, %0d matches and %0d image totals, %0d register writes",
               pixels_taken, hits_seen, images_done, csr_writes);
      $display("Mismatches found: %0d", mismatch_count);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // watchdog
   initial begin
      #15_000_000;
      $display("Timeout: %0d results still outstanding", reports_due.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
